/* rtl/overwriting_record_log_ring_assert.svh */
// Assertion macros for the log ring
`ifndef OVERWRITING_RECORD_LOG_RING_ASSERT_SVH
`define OVERWRITING_RECORD_LOG_RING_ASSERT_SVH

`define ORL_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define ORL_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* rtl/orl_pkg.sv */
package orl_pkg;
  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned HdrBytes    = 7;
  localparam int unsigned CntW        = 11;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_DATA  = 2'd1,
    FN_REW   = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LONG = 2'd1,
    ST_SEQ  = 2'd2,
    ST_END  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_HDR  = 2'd1,
    K_BYTE = 2'd2
  } kind_t;

  localparam logic [0:0] RegRingSize = 1'b0;
endpackage

/* rtl/overwriting_record_log_ring.sv */
// Overwriting record log ring.
// Channels: command input (start high while busy low accepts one word),
// result output (out_valid high for one cycle per word, cannot be stalled),
// APB-style configuration port with ring_size at address 0.
// Each accepted word yields exactly one result word.
// Steps per word: payload, rewind and rejected words go straight to the
// result; a read fetches a payload byte with one memory read, or a header
// with one memory read per stored byte, stopping early when a short record
// ends the walk; a start evicts old records as needed, then does 7 header
// writes.
// The byte store is one synchronous RAM with a registered read; it has one
// write port and one read port.
// busy is high from acceptance through the result cycle, so one word is in
// flight at a time; the next word can be accepted right after the result.
// Reset (rst_n low, synchronous) empties the ring and sets ring_size to
// 1024; the RAM holds no reset and needs no clearing pass.
// Writing ring_size also empties the ring; write only while idle.
// The receiver cannot stall: a result is shown for one cycle only.
module overwriting_record_log_ring #(
  parameter int unsigned CAPACITY = orl_pkg::CapacityDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_magic,
  input  logic [7:0]  in_record_len,
  input  logic [7:0]  in_record_type,
  input  logic [31:0] in_timestamp,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_out_kind,
  output logic [7:0]  out_out_magic,
  output logic [7:0]  out_out_len,
  output logic [7:0]  out_out_type,
  output logic [31:0] out_out_timestamp,
  output logic [7:0]  out_out_byte,
  output logic        out_last,
  output logic [10:0] out_evicted,
  output logic [10:0] out_bytes_used,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import orl_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = (SW > CntW) ? SW : CntW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVRD  = 7'b0000010,
    S_EVUP  = 7'b0000100,
    S_HWR   = 7'b0001000,
    S_RDHD  = 7'b0010000,
    S_RDBY  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rdata_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  logic [10:0]   ring_size_r;
  logic [AW-1:0] wp_r, wp_nxt, op_r, op_nxt, rp_r, rp_nxt;
  logic [CW-1:0] used_r, used_nxt, rrem_r, rrem_nxt;
  logic [7:0]    pl_r, pl_nxt, rpl_r, rpl_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [10:0]   ev_r, ev_nxt;
  logic [7:0]    magic_r, len_r, type_r;
  logic [31:0]   ts_r;
  logic [63:0]   hdr_r, hdr_nxt;

  logic [1:0]  st_r, st_nxt, kind_r, kind_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        last_r, last_nxt;

  logic [SW-1:0] size;
  logic [AW-1:0] ptr_a, ptr_q;
  logic [SW-1:0] ptr_n;
  logic [CW-1:0] total, drop_total;
  logic          cfg_wr;

  always_comb begin
    if (ring_size_r < 11'd8) size = SW'(8);
    else if (32'(ring_size_r) > CAPACITY) size = SW'(CAPACITY);
    else size = SW'(ring_size_r);
  end

  orl_ptr_add #(.PW(AW)) u_add (.p(ptr_a), .n(ptr_n), .size(size), .q(ptr_q));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegRingSize);
  assign prdata = (paddr == RegRingSize) ? {21'd0, ring_size_r} : 32'd0;
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign total      = CW'(HdrBytes) + CW'(len_r);
  assign drop_total = CW'(HdrBytes) + CW'(rdata_r);

  always_comb begin
    state_nxt = state_r;
    wp_nxt = wp_r; op_nxt = op_r; rp_nxt = rp_r;
    used_nxt = used_r; rrem_nxt = rrem_r; pl_nxt = pl_r; rpl_nxt = rpl_r;
    cnt_nxt = cnt_r; ev_nxt = ev_r; hdr_nxt = hdr_r;
    st_nxt = st_r; kind_nxt = kind_r; ob_nxt = ob_r; last_nxt = last_r;
    we = 1'b0; waddr = wp_r; wdata = 8'd0; raddr = rp_r;
    ptr_a = wp_r; ptr_n = SW'(1);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = ST_OK; kind_nxt = K_NONE; ob_nxt = '0; last_nxt = 1'b0;
          ev_nxt = '0; hdr_nxt = '0; cnt_nxt = '0;
          state_nxt = S_DONE;
          unique case (func_t'(in_func))
            FN_START: begin
              if (pl_r != 8'd0) st_nxt = ST_SEQ;
              else if (CW'(HdrBytes) + CW'(in_record_len) > CW'(size)) st_nxt = ST_LONG;
              else state_nxt = S_EVRD;
            end
            FN_DATA: begin
              if (pl_r == 8'd0) st_nxt = ST_SEQ;
              else begin
                we = 1'b1; waddr = wp_r; wdata = in_data_byte;
                wp_nxt = ptr_q; pl_nxt = pl_r - 8'd1;
              end
            end
            FN_REW: begin
              if (pl_r != 8'd0) st_nxt = ST_SEQ;
              else begin
                rp_nxt = op_r; rrem_nxt = used_r; rpl_nxt = '0;
              end
            end
            FN_READ: begin
              if (pl_r != 8'd0) st_nxt = ST_SEQ;
              else if (rpl_r != 8'd0) begin
                raddr = rp_r; state_nxt = S_RDBY;
              end else if (rrem_r >= CW'(HdrBytes)) begin
                raddr = rp_r; ptr_a = rp_r; ptr_n = SW'(1);
                rp_nxt = ptr_q; state_nxt = S_RDHD;
              end else st_nxt = ST_END;
            end
            default: ;
          endcase
        end
      end
      S_EVRD: begin
        if (used_r + total > CW'(size)) begin
          ptr_a = op_r; ptr_n = SW'(1); raddr = ptr_q;
          state_nxt = S_EVUP;
        end else state_nxt = S_HWR;
      end
      S_EVUP: begin
        ev_nxt = ev_r + 11'd1;
        ptr_a = op_r; ptr_n = SW'(drop_total);
        if (drop_total >= used_r) begin
          used_nxt = '0; op_nxt = wp_r;
        end else begin
          used_nxt = used_r - drop_total; op_nxt = ptr_q;
        end
        state_nxt = S_EVRD;
      end
      S_HWR: begin
        we = 1'b1; waddr = wp_r;
        case (cnt_r)
          3'd0: wdata = magic_r;
          3'd1: wdata = len_r;
          3'd2: wdata = type_r;
          3'd3: wdata = ts_r[7:0];
          3'd4: wdata = ts_r[15:8];
          3'd5: wdata = ts_r[23:16];
          default: wdata = ts_r[31:24];
        endcase
        ptr_a = wp_r; ptr_n = SW'(1); wp_nxt = ptr_q;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          used_nxt = used_r + total; pl_nxt = len_r;
          rrem_nxt = '0; rpl_nxt = '0;
          state_nxt = S_DONE;
        end
      end
      S_RDHD: begin
        // rp_r runs one ahead of the data returned; cnt_r counts bytes seen
        raddr = rp_r; ptr_a = rp_r; ptr_n = SW'(1);
        hdr_nxt = hdr_r | (64'(rdata_r) << {cnt_r, 3'b000});
        if (cnt_r == 3'd1 && rrem_r < CW'(HdrBytes) + CW'(rdata_r)) begin
          st_nxt = ST_END; rrem_nxt = '0; state_nxt = S_DONE;
          rp_nxt = rp_r;
        end else if (cnt_r == 3'd6) begin
          kind_nxt = K_HDR;
          rrem_nxt = rrem_r - CW'(HdrBytes) - CW'(hdr_r[15:8]);
          rpl_nxt = hdr_r[15:8];
          last_nxt = (hdr_r[15:8] == 8'd0);
          state_nxt = S_DONE;
        end else begin
          rp_nxt = ptr_q; cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_RDBY: begin
        kind_nxt = K_BYTE; ob_nxt = rdata_r;
        ptr_a = rp_r; ptr_n = SW'(1); rp_nxt = ptr_q;
        rpl_nxt = rpl_r - 8'd1;
        last_nxt = (rpl_r == 8'd1);
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ring_size_r <= 11'd1024;
      wp_r <= '0; op_r <= '0; rp_r <= '0;
      used_r <= '0; rrem_r <= '0; pl_r <= '0; rpl_r <= '0;
      cnt_r <= '0; ev_r <= '0;
    end else if (cfg_wr) begin
      ring_size_r <= pwdata[10:0];
      wp_r <= '0; op_r <= '0; rp_r <= '0;
      used_r <= '0; rrem_r <= '0; pl_r <= '0; rpl_r <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r <= wp_nxt; op_r <= op_nxt; rp_r <= rp_nxt;
      used_r <= used_nxt; rrem_r <= rrem_nxt; pl_r <= pl_nxt; rpl_r <= rpl_nxt;
      cnt_r <= cnt_nxt; ev_r <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt; st_r <= st_nxt; kind_r <= kind_nxt;
    ob_r <= ob_nxt; last_r <= last_nxt;
    if (state_r == S_IDLE && start) begin
      magic_r <= in_magic; len_r <= in_record_len;
      type_r <= in_record_type; ts_r <= in_timestamp;
    end
  end

  assign out_valid         = (state_r == S_DONE);
  assign out_status        = st_r;
  assign out_out_kind      = kind_r;
  assign out_out_magic     = (kind_r == K_HDR) ? hdr_r[7:0] : 8'd0;
  assign out_out_len       = (kind_r == K_HDR) ? hdr_r[15:8] : 8'd0;
  assign out_out_type      = (kind_r == K_HDR) ? hdr_r[23:16] : 8'd0;
  assign out_out_timestamp = (kind_r == K_HDR) ? hdr_r[55:24] : 32'd0;
  assign out_out_byte      = ob_r;
  assign out_last          = last_r;
  assign out_evicted       = ev_r;
  assign out_bytes_used    = used_r[10:0];

`include "overwriting_record_log_ring_assert.svh"

  `ORL_ASSERT_IMPL(a_used_le_size, clk, rst_n, 1'b1, used_r <= CW'(size))
  `ORL_ASSERT_NEXT(a_done_idle, clk, rst_n, out_valid, !out_valid)
  `ORL_ASSERT_IMPL(a_kind_ok, clk, rst_n, out_valid && out_out_kind != K_NONE,
                   out_status == ST_OK)
endmodule

/* rtl/orl_ptr_add.sv */
// Modular pointer add: (p + n) mod size for p < size, n < size
module orl_ptr_add #(
  parameter int unsigned PW = 10
) (
  input  logic [PW-1:0] p,
  input  logic [PW:0]   n,
  input  logic [PW:0]   size,
  output logic [PW-1:0] q
);
  logic [PW+1:0] s;
  logic [PW+1:0] d;
  always_comb begin
    s = {1'b0, p} + {1'b0, n};
    d = s - {1'b0, size};
    q = (s >= {1'b0, size}) ? d[PW-1:0] : s[PW-1:0];
  end
endmodule
